// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
    else $error("assertion failed");

`endif

// ===== rtl/lbsa_pkg.sv =====
// Types, codes and sizes shared by the label block sum accumulator modules.
package lbsa_pkg;

  localparam int unsigned MAX_NODES   = 1024;
  localparam int unsigned MAX_BLOCKS  = 16;
  localparam int unsigned WEIGHT_BITS = 16;

  localparam int unsigned NODE_W  = 10;
  localparam int unsigned LABEL_W = 4;
  localparam int unsigned NB_W    = 5;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned PCNT_W  = 21;
  localparam int unsigned SUM_AW  = 2 * LABEL_W;
  localparam int unsigned LENT_W  = LABEL_W + 1;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic CFG_NUM_BLOCKS = 1'b0;
  localparam logic CFG_HALVE_DIAG = 1'b1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [NODE_W-1:0]  node_row;
    logic [NODE_W-1:0]  node_col;
    logic [LABEL_W-1:0] label;
    logic [15:0]        weight;
    logic [LABEL_W-1:0] block_a;
    logic [LABEL_W-1:0] block_b;
  } in_t;

  typedef struct packed {
    logic [SUM_W-1:0]  pair_sum;
    logic [PCNT_W-1:0] pair_count;
    logic              error_seen;
  } out_t;

  typedef struct packed {
    in_t  item;
    logic label_bad;
    logic pair_bad;
  } qitem_t;

endpackage

// ===== rtl/lbsa_ram.sv =====
// Generic single write port RAM with one registered read port.
module lbsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lbsa_front.sv =====
// Input side: classifies items against the registers and queues them.
module lbsa_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  lbsa_pkg::in_t          in_data,
  input  logic [lbsa_pkg::NB_W-1:0] nb,
  input  logic                   clearing,
  output logic                   q_valid,
  output lbsa_pkg::qitem_t       q_item,
  input  logic                   q_pop
);

  lbsa_pkg::qitem_t entry_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       fill_r, fill_nxt;
  logic             push;
  lbsa_pkg::qitem_t cls;

  always_comb begin
    cls.item      = in_data;
    cls.label_bad = {1'b0, in_data.label} >= nb;
    cls.pair_bad  = ({1'b0, in_data.block_a} >= nb) || ({1'b0, in_data.block_b} >= nb);
  end

  assign in_stall = fill_r[1] || clearing;
  assign push     = in_valid && !in_stall;
  assign q_valid  = fill_r != 2'd0;
  assign q_item   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== rtl/lbsa_back.sv =====
// Execution side: sequencer over the label and sum memories and the counts.
module lbsa_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  lbsa_pkg::qitem_t          q_item,
  output logic                      q_pop,
  input  logic [lbsa_pkg::NB_W-1:0] nb,
  input  logic                      halve,
  output logic                      clearing,
  output logic                      out_valid,
  input  logic                      out_stall,
  output lbsa_pkg::out_t            out_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LD   = 4'd1;
  localparam logic [3:0] S_NZ1  = 4'd2;
  localparam logic [3:0] S_NZ2  = 4'd3;
  localparam logic [3:0] S_NZ3  = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_RD2  = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;
  localparam logic [3:0] S_CLR  = 4'd8;

  localparam int unsigned NW = lbsa_pkg::NODE_W;
  localparam int unsigned LW = lbsa_pkg::LABEL_W;
  localparam int unsigned CW = lbsa_pkg::CNT_W;
  localparam int unsigned SW = lbsa_pkg::SUM_W;
  localparam int unsigned PW = lbsa_pkg::PCNT_W;
  localparam int unsigned AW = lbsa_pkg::SUM_AW;
  localparam int unsigned EW = lbsa_pkg::LENT_W;

  logic [3:0]        state_r, state_nxt;
  lbsa_pkg::in_t     cur_r, cur_nxt;
  logic [NW-1:0]     clr_idx_r, clr_idx_nxt;
  logic [CW-1:0]     cnt_r [lbsa_pkg::MAX_BLOCKS];
  logic [CW-1:0]     cnt_nxt [lbsa_pkg::MAX_BLOCKS];
  logic              err_r, err_nxt;
  logic [EW-1:0]     rowd_r, rowd_nxt;
  logic [AW-1:0]     saddr_r, saddr_nxt;
  logic [SW-1:0]     sum_r, sum_nxt;
  logic [CW-1:0]     ca_r, ca_nxt;
  logic [2*CW-1:0]   prod_r, prod_nxt;
  logic              out_valid_r, out_valid_nxt;
  lbsa_pkg::out_t    out_data_r, out_data_nxt;

  logic              lab_we;
  logic [NW-1:0]     lab_waddr, lab_raddr;
  logic [EW-1:0]     lab_wdata, lab_rdata;
  logic              sum_we;
  logic [AW-1:0]     sum_waddr, sum_raddr;
  logic [SW-1:0]     sum_wdata, sum_rdata;

  logic [LW-1:0]     cnt_idx;
  logic [CW-1:0]     cnt_sel;
  logic [CW-1:0]     mul_b;
  logic              diag, halving, out_free;
  logic [SW:0]       sum_add;
  logic [2*CW-1:0]   pc_half;
  logic [SW-1:0]     wmask;

  lbsa_ram #(.WIDTH(EW), .DEPTH(lbsa_pkg::MAX_NODES)) u_lab_ram (
    .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
    .raddr(lab_raddr), .rdata(lab_rdata)
  );

  lbsa_ram #(.WIDTH(SW), .DEPTH(lbsa_pkg::MAX_BLOCKS * lbsa_pkg::MAX_BLOCKS)) u_sum_ram (
    .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
    .raddr(sum_raddr), .rdata(sum_rdata)
  );

  assign clearing  = state_r == S_CLR;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign diag      = cur_r.block_a == cur_r.block_b;
  assign halving   = diag && halve;
  assign cnt_idx   = (state_r == S_RD) ? cur_r.block_a : cur_r.block_b;
  assign cnt_sel   = cnt_r[cnt_idx];
  assign wmask     = SW'((49'd1 << lbsa_pkg::WEIGHT_BITS) - 49'd1);
  assign sum_add   = {1'b0, sum_rdata} + {1'b0, SW'(cur_r.weight) & wmask};
  assign pc_half   = halving ? (prod_r >> 1) : prod_r;

  always_comb begin
    if (!diag) begin
      mul_b = cnt_sel;
    end else if (ca_r == '0) begin
      mul_b = '0;
    end else begin
      mul_b = ca_r - CW'(1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    clr_idx_nxt   = clr_idx_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    rowd_nxt      = rowd_r;
    saddr_nxt     = saddr_r;
    sum_nxt       = sum_r;
    ca_nxt        = ca_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    lab_we        = 1'b0;
    lab_waddr     = cur_r.node_row;
    lab_wdata     = {1'b1, cur_r.label};
    lab_raddr     = q_item.item.node_row;
    sum_we        = 1'b0;
    sum_waddr     = saddr_r;
    sum_wdata     = sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
    sum_raddr     = {q_item.item.block_a, q_item.item.block_b};
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_item.item;
          unique case (q_item.item.cmd)
            lbsa_pkg::CMD_LOAD: begin
              if (q_item.label_bad) begin
                err_nxt = 1'b1;
              end else begin
                state_nxt = S_LD;
              end
            end
            lbsa_pkg::CMD_ADD: begin
              state_nxt = S_NZ1;
            end
            lbsa_pkg::CMD_READ: begin
              if (q_item.pair_bad) begin
                err_nxt = 1'b1;
              end else begin
                state_nxt = S_RD;
              end
            end
            lbsa_pkg::CMD_CLEAR: begin
              state_nxt   = S_CLR;
              clr_idx_nxt = '0;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_LD: begin
        lab_we = 1'b1;
        for (int b = 0; b < lbsa_pkg::MAX_BLOCKS; b++) begin
          if (lab_rdata[EW-1] && lab_rdata[LW-1:0] == LW'(b) && cnt_r[b] != '0) begin
            cnt_nxt[b] = cnt_r[b] - CW'(1);
          end
          if (cur_r.label == LW'(b)) begin
            cnt_nxt[b] = cnt_nxt[b] + CW'(1);
          end
        end
        state_nxt = S_IDLE;
      end
      S_NZ1: begin
        lab_raddr = cur_r.node_col;
        rowd_nxt  = lab_rdata;
        state_nxt = S_NZ2;
      end
      S_NZ2: begin
        sum_raddr = {rowd_r[LW-1:0], lab_rdata[LW-1:0]};
        saddr_nxt = {rowd_r[LW-1:0], lab_rdata[LW-1:0]};
        if (!rowd_r[EW-1] || !lab_rdata[EW-1] ||
            {1'b0, rowd_r[LW-1:0]} >= nb || {1'b0, lab_rdata[LW-1:0]} >= nb) begin
          err_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_NZ3;
        end
      end
      S_NZ3: begin
        sum_we    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RD: begin
        sum_nxt   = sum_rdata;
        ca_nxt    = cnt_sel;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        prod_nxt  = ca_r * mul_b;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.pair_sum   = halving ? (sum_r >> 1) : sum_r;
          out_data_nxt.pair_count = (pc_half > (2*CW)'({PW{1'b1}})) ? {PW{1'b1}}
                                                                   : pc_half[PW-1:0];
          out_data_nxt.error_seen = err_r;
          state_nxt               = S_IDLE;
        end
      end
      S_CLR: begin
        lab_we    = 1'b1;
        lab_waddr = clr_idx_r;
        lab_wdata = '0;
        sum_we    = clr_idx_r < NW'(lbsa_pkg::MAX_BLOCKS * lbsa_pkg::MAX_BLOCKS);
        sum_waddr = clr_idx_r[AW-1:0];
        sum_wdata = '0;
        err_nxt   = 1'b0;
        for (int b = 0; b < lbsa_pkg::MAX_BLOCKS; b++) begin
          cnt_nxt[b] = '0;
        end
        clr_idx_nxt = clr_idx_r + NW'(1);
        if (clr_idx_r == NW'(lbsa_pkg::MAX_NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int b = 0; b < lbsa_pkg::MAX_BLOCKS; b++) begin
        cnt_r[b] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    rowd_r     <= rowd_nxt;
    saddr_r    <= saddr_nxt;
    sum_r      <= sum_nxt;
    ca_r       <= ca_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/label_block_sum_accumulator_top.sv =====
// Top level of the label block sum accumulator.
//
// Items arrive on the in_ channel (valid and stall); a transfer takes place at a
// rising edge with in_valid high and in_stall low. Commands load a node label,
// add a nonzero (row, column, weight), read a block pair or clear everything.
// Only a read of a valid pair gives a result, on the out_ channel, carrying the
// pair sum, the pair count and the sticky error flag.
// A two-entry queue sits between the input side and the sequencer. The sequencer
// handles one item at a time: a load passes through S_LD, a nonzero through S_NZ1,
// S_NZ2 and S_NZ3, a read through S_RD, S_RD2 and S_OUT plus any wait for the
// output register; a rejected load or read is dropped in the idle state and a
// rejected nonzero after S_NZ2. The single read port of the label memory and of
// the sum memory sets these steps. Reset and the clear command run a clearing pass
// over the label and sum memories, during which in_stall is high; registers may
// still be written. When the receiver stalls, the result waits in the output
// register while the queue continues to take items.
module label_block_sum_accumulator_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lbsa_pkg::in_t        in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lbsa_pkg::out_t       out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [lbsa_pkg::NB_W-1:0] cfg_wdata
);

  logic [lbsa_pkg::NB_W-1:0] num_blocks_r;
  logic                      halve_diag_r;
  logic [lbsa_pkg::NB_W-1:0] nb;
  logic                      clearing;
  logic                      q_valid, q_pop;
  lbsa_pkg::qitem_t          q_item;

  assign nb = (num_blocks_r > lbsa_pkg::NB_W'(lbsa_pkg::MAX_BLOCKS))
              ? lbsa_pkg::NB_W'(lbsa_pkg::MAX_BLOCKS) : num_blocks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_blocks_r <= lbsa_pkg::NB_W'(16);
      halve_diag_r <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == lbsa_pkg::CFG_NUM_BLOCKS) begin
        num_blocks_r <= cfg_wdata;
      end else begin
        halve_diag_r <= cfg_wdata[0];
      end
    end
  end

  lbsa_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .nb(nb), .clearing(clearing),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  lbsa_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .nb(nb), .halve(halve_diag_r), .clearing(clearing),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

// ===== rtl/lbsa_checker.sv =====
// Port checker for the label block sum accumulator, bound to the top level.
`include "assert_macros.svh"

module lbsa_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input lbsa_pkg::out_t out_data
);

  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
  `ASSERT_SAME(a_clear_after_reset, $rose(rst_n), in_stall)
  `ASSERT_SAME(a_no_out_after_reset, $rose(rst_n), !out_valid)

endmodule

bind label_block_sum_accumulator_top lbsa_checker u_lbsa_checker (.*);
